// ----- hw/rtl/npcd_pkg.sv -----
// Package for the nibble permutation cipher decrypt core.
// Holds request types, key constants and the per-round permutation logic.
// No dependencies.
package npcd_pkg;

	localparam int ROUNDS     = 10;
	localparam int KEY_W      = 5;
	localparam int KEY_MOD    = 24;
	localparam int ROUND_STEP = ROUNDS % KEY_MOD;

	localparam logic [KEY_W-1:0] KEY_MOD_C  = KEY_W'(KEY_MOD);
	localparam logic [KEY_W-1:0] KEY_LAST_C = KEY_W'(KEY_MOD - 1);
	localparam logic [KEY_W-1:0] STEP_C     = KEY_W'(ROUND_STEP);
	localparam logic [KEY_W-1:0] STEP_WRAP_C = KEY_W'(KEY_MOD - ROUND_STEP);

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       restart;
	} npcd_in_t;

	typedef struct packed {
		logic [7:0]       plain_byte;
		logic [KEY_W-1:0] key_after;
	} npcd_out_t;

	typedef struct packed {
		logic [7:0]       data;
		logic [KEY_W-1:0] key;
	} npcd_stage_t;

	function automatic logic [KEY_W-1:0] key_down(input logic [KEY_W-1:0] k);
		return (k == '0) ? KEY_LAST_C : k - KEY_W'(1);
	endfunction

	// Lexicographic permutation of 0..3; entry i sits at bits [2i+1:2i].
	function automatic logic [7:0] perm_entry(input logic [KEY_W-1:0] k);
		logic [7:0] p;
		unique case (k)
			5'd0:    p = {2'd3, 2'd2, 2'd1, 2'd0};
			5'd1:    p = {2'd2, 2'd3, 2'd1, 2'd0};
			5'd2:    p = {2'd3, 2'd1, 2'd2, 2'd0};
			5'd3:    p = {2'd1, 2'd3, 2'd2, 2'd0};
			5'd4:    p = {2'd2, 2'd1, 2'd3, 2'd0};
			5'd5:    p = {2'd1, 2'd2, 2'd3, 2'd0};
			5'd6:    p = {2'd3, 2'd2, 2'd0, 2'd1};
			5'd7:    p = {2'd2, 2'd3, 2'd0, 2'd1};
			5'd8:    p = {2'd3, 2'd0, 2'd2, 2'd1};
			5'd9:    p = {2'd0, 2'd3, 2'd2, 2'd1};
			5'd10:   p = {2'd2, 2'd0, 2'd3, 2'd1};
			5'd11:   p = {2'd0, 2'd2, 2'd3, 2'd1};
			5'd12:   p = {2'd3, 2'd1, 2'd0, 2'd2};
			5'd13:   p = {2'd1, 2'd3, 2'd0, 2'd2};
			5'd14:   p = {2'd3, 2'd0, 2'd1, 2'd2};
			5'd15:   p = {2'd0, 2'd3, 2'd1, 2'd2};
			5'd16:   p = {2'd1, 2'd0, 2'd3, 2'd2};
			5'd17:   p = {2'd0, 2'd1, 2'd3, 2'd2};
			5'd18:   p = {2'd2, 2'd1, 2'd0, 2'd3};
			5'd19:   p = {2'd1, 2'd2, 2'd0, 2'd3};
			5'd20:   p = {2'd2, 2'd0, 2'd1, 2'd3};
			5'd21:   p = {2'd0, 2'd2, 2'd1, 2'd3};
			5'd22:   p = {2'd1, 2'd0, 2'd2, 2'd3};
			5'd23:   p = {2'd0, 2'd1, 2'd2, 2'd3};
			default: p = {2'd3, 2'd2, 2'd1, 2'd0};
		endcase
		return p;
	endfunction

	// One round on one nibble; k is the already stepped key.
	function automatic logic [3:0] round_nibble(input logic [3:0] nib,
	                                            input logic [KEY_W-1:0] k);
		logic [7:0] p;
		logic [7:0] inv;
		logic [3:0] moved;
		logic [1:0] v;
		logic [1:0] s;
		logic [3:0] e;
		p     = perm_entry(k);
		inv   = '0;
		moved = '0;
		e     = '0;
		for (int i = 0; i < 4; i++) begin
			moved[p[2*i +: 2]]   = nib[i];
			inv[2*p[2*i +: 2] +: 2] = 2'(i);
		end
		for (int j = 0; j < 2; j++) begin
			v = {moved[2*j], moved[2*j+1]};
			s = inv[2*v +: 2];
			e[2*j]   = s[1];
			e[2*j+1] = s[0];
		end
		return e;
	endfunction

endpackage

// ----- hw/rtl/npcd_cell.sv -----
// One round cell of the decrypt chain: steps the key, permutes both nibbles,
// registers the result. Depends on npcd_pkg.
module npcd_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  npcd_pkg::npcd_stage_t up_stage,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output npcd_pkg::npcd_stage_t dn_stage
);
	import npcd_pkg::*;

	logic             valid_q;
	npcd_stage_t      stage_q;
	logic [KEY_W-1:0] key_next;

	assign up_ready = !valid_q || dn_ready;
	assign key_next = key_down(up_stage.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			stage_q.data <= {round_nibble(up_stage.data[7:4], key_next),
			                 round_nibble(up_stage.data[3:0], key_next)};
			stage_q.key  <= key_next;
		end
	end

	assign dn_valid = valid_q;
	assign dn_stage = stage_q;

endmodule

// ----- hw/rtl/nibble_permutation_cipher_decrypt_core.sv -----
// Top level of the nibble permutation cipher decrypt core.
// Key residue tracking and a chain of npcd_cell round cells; uses npcd_pkg.
//
//   port group                 dir  payload
//   cipher_valid/ready/cipher  in   npcd_in_t  (cipher_byte, restart)
//   plain_valid/ready/plain    out  npcd_out_t (plain_byte, key_after)
//   cfg_we/cfg_wdata           in   start_key, written when cfg_we is high
//
// One request per cycle while the output is not stalled; each round cell registers its round.
// The key residue for the next request is updated on acceptance, so it never
// waits on the chain. Each cell holds while the one after it is full and
// stalled; bubbles are squeezed out. Reset empties the chain and clears the
// residue and start_key.
module nibble_permutation_cipher_decrypt_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cipher_valid,
	output logic                 cipher_ready,
	input  npcd_pkg::npcd_in_t   cipher,
	output logic                 plain_valid,
	input  logic                 plain_ready,
	output npcd_pkg::npcd_out_t  plain,
	input  logic                 cfg_we,
	input  logic [npcd_pkg::KEY_W-1:0] cfg_wdata
);
	import npcd_pkg::*;

	logic [KEY_W-1:0] start_key_q;
	logic [KEY_W-1:0] key_residue_q;
	logic [KEY_W-1:0] key_start;
	logic [KEY_W-1:0] key_load;
	logic [KEY_W-1:0] key_after;

	logic        chain_valid [ROUNDS+1];
	logic        chain_ready [ROUNDS+1];
	npcd_stage_t chain_stage [ROUNDS+1];

	assign key_load  = (start_key_q >= KEY_MOD_C) ? start_key_q - KEY_MOD_C : start_key_q;
	assign key_start = cipher.restart ? key_load : key_residue_q;
	assign key_after = (key_start >= STEP_C) ? key_start - STEP_C : key_start + STEP_WRAP_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_key_q   <= '0;
			key_residue_q <= '0;
		end else begin
			if (cfg_we) begin
				start_key_q <= cfg_wdata;
			end
			if (cipher_valid && cipher_ready) begin
				key_residue_q <= key_after;
			end
		end
	end

	assign chain_valid[0]      = cipher_valid;
	assign cipher_ready        = chain_ready[0];
	assign chain_stage[0].data = cipher.cipher_byte;
	assign chain_stage[0].key  = key_start;

	for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
		npcd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[g]),
			.up_ready (chain_ready[g]),
			.up_stage (chain_stage[g]),
			.dn_valid (chain_valid[g+1]),
			.dn_ready (chain_ready[g+1]),
			.dn_stage (chain_stage[g+1])
		);
	end

	assign chain_ready[ROUNDS] = plain_ready;
	assign plain_valid         = chain_valid[ROUNDS];
	assign plain.plain_byte    = chain_stage[ROUNDS].data;
	assign plain.key_after     = chain_stage[ROUNDS].key;

endmodule

// ----- tb/npcd_checker.sv -----
// Checker for the nibble permutation cipher decrypt core: tracks start_key writes
// and the key residue, predicts each plain byte and compares results in order.
// Depends on npcd_pkg for the request and result types and the key constants.
module npcd_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cipher_valid,
	input  logic                       cipher_ready,
	input  npcd_pkg::npcd_in_t         cipher,
	input  logic                       plain_valid,
	input  logic                       plain_ready,
	input  npcd_pkg::npcd_out_t        plain,
	input  logic                       cfg_we,
	input  logic [npcd_pkg::KEY_W-1:0] cfg_wdata,
	output int                         errors,
	output int                         pending,
	output int                         checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import npcd_pkg::*;

	typedef logic [3:0][1:0] perm_t;

	perm_t            perm_lut [KEY_MOD];
	logic [KEY_W-1:0] start_key_q   = '0;
	logic [KEY_W-1:0] key_residue_q = '0;
	npcd_out_t        plain_q [$];

	initial begin
		int n;
		n = 0;
		for (int a = 0; a < 4; a++)
			for (int b = 0; b < 4; b++)
				for (int c = 0; c < 4; c++)
					for (int d = 0; d < 4; d++)
						if (a != b && a != c && a != d && b != c && b != d && c != d) begin
							perm_lut[n] = {2'(d), 2'(c), 2'(b), 2'(a)};
							n++;
						end
	end

	function automatic logic [KEY_W-1:0] key_step_down(input logic [KEY_W-1:0] k);
		return (k == '0) ? KEY_W'(KEY_MOD - 1) : k - KEY_W'(1);
	endfunction

	function automatic logic [3:0] unscramble_nibble(input logic [3:0] nib,
	                                                 input logic [KEY_W-1:0] key);
		logic [3:0]       e;
		logic [3:0]       moved;
		logic [1:0]       v;
		logic [1:0]       s;
		logic [KEY_W-1:0] k;
		perm_t            p;
		e = nib;
		k = key;
		moved = '0;
		s = '0;
		for (int r = 0; r < ROUNDS; r++) begin
			k = key_step_down(k);
			p = perm_lut[k];
			for (int i = 0; i < 4; i++)
				moved[p[i]] = e[i];
			for (int j = 0; j < 2; j++) begin
				v = {moved[2*j], moved[2*j+1]};
				for (int i = 0; i < 4; i++)
					if (p[i] == v)
						s = 2'(i);
				e[2*j]   = s[1];
				e[2*j+1] = s[0];
			end
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		npcd_out_t expected;
		if (!arst_n) begin
			start_key_q   = '0;
			key_residue_q = '0;
			plain_q.delete();
			pending <= 0;
			errors  <= 0;
			checked <= 0;
		end else begin
			if (cfg_we)
				start_key_q = cfg_wdata;
			if (cipher_valid && cipher_ready) begin
				if (cipher.restart)
					key_residue_q = KEY_W'(start_key_q % KEY_MOD);
				expected.plain_byte = {unscramble_nibble(cipher.cipher_byte[7:4], key_residue_q),
				                       unscramble_nibble(cipher.cipher_byte[3:0], key_residue_q)};
				for (int r = 0; r < ROUNDS; r++)
					key_residue_q = key_step_down(key_residue_q);
				expected.key_after = key_residue_q;
				plain_q.push_back(expected);
			end
			if (plain_valid && plain_ready) begin
				if (plain_q.size() == 0) begin
					$display("%0t: result with no request pending: plain_byte %02h key_after %0d",
					         $time, plain.plain_byte, plain.key_after);
					errors <= errors + 1;
				end else begin
					expected = plain_q.pop_front();
					checked <= checked + 1;
					if (plain.plain_byte !== expected.plain_byte ||
					    plain.key_after !== expected.key_after) begin
						if (plain.plain_byte !== expected.plain_byte)
							$display("%0t: plain_byte mismatch: expected %02h, actual %02h",
							         $time, expected.plain_byte, plain.plain_byte);
						if (plain.key_after !== expected.key_after)
							$display("%0t: key_after mismatch: expected %0d, actual %0d",
							         $time, expected.key_after, plain.key_after);
						errors <= errors + 1;
					end
				end
			end
			pending <= plain_q.size();
		end
	end

endmodule

// ----- tb/nibble_permutation_cipher_decrypt_core_test.sv -----
// Top of the decrypt core testbench: clock, reset, request and start_key stimulus,
// random back-pressure and the verdict. Uses npcd_pkg, npcd_checker and the core.
module nibble_permutation_cipher_decrypt_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import npcd_pkg::*;

	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 200;
	localparam int PHASE_ITEMS  = 180;
	localparam int RANDOM_PHASES = 8;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cipher_valid = 1'b0;
	logic             cipher_ready;
	npcd_in_t         cipher       = '0;
	logic             plain_valid;
	logic             plain_ready  = 1'b0;
	npcd_out_t        plain;
	logic             cfg_we       = 1'b0;
	logic [KEY_W-1:0] cfg_wdata    = '0;

	int  errors;
	int  pending;
	int  checked;
	int  sent       = 0;
	int  restarts   = 0;
	int  key_writes = 0;
	int  hold_req   = 0;
	int  hold_done  = 0;
	int  quiet      = 0;
	bit  burst      = 1'b0;

	nibble_permutation_cipher_decrypt_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cipher_valid (cipher_valid),
		.cipher_ready (cipher_ready),
		.cipher       (cipher),
		.plain_valid  (plain_valid),
		.plain_ready  (plain_ready),
		.plain        (plain),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	npcd_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cipher_valid (cipher_valid),
		.cipher_ready (cipher_ready),
		.cipher       (cipher),
		.plain_valid  (plain_valid),
		.plain_ready  (plain_ready),
		.plain        (plain),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				plain_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else begin
				plain_ready <= burst ? 1'b1 : ($urandom_range(99) >= 29);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n || (cipher_valid && cipher_ready) || (plain_valid && plain_ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("nibble_permutation_cipher_decrypt_core_test NOT OK");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [7:0] byte_in, input logic restart_in);
		npcd_in_t req;
		req.cipher_byte = byte_in;
		req.restart     = restart_in;
		while (!burst && $urandom_range(99) < 29) begin
			cipher_valid <= 1'b0;
			@(posedge clk);
		end
		cipher       <= req;
		cipher_valid <= 1'b1;
		@(posedge clk);
		while (!cipher_ready) @(posedge clk);
		sent++;
		if (restart_in)
			restarts++;
	endtask

	task automatic drain();
		cipher_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_start_key(input logic [KEY_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_writes++;
	endtask

	initial begin
		logic [KEY_W-1:0] phase_key;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset residue first, then a restart from the reset start_key
		send_request(8'h00, 1'b0);
		send_request(8'hff, 1'b0);
		send_request(8'h0f, 1'b0);
		send_request(8'hf0, 1'b0);
		send_request(8'h55, 1'b0);
		send_request(8'haa, 1'b0);
		send_request(8'h01, 1'b1);
		send_request(8'h80, 1'b0);
		send_request(8'h7e, 1'b0);
		drain();
		write_start_key(5'd31);
		send_request(8'h3c, 1'b1);
		send_request(8'hc3, 1'b0);
		send_request(8'hff, 1'b1);
		drain();
		write_start_key(5'd24);
		send_request(8'h96, 1'b1);
		send_request(8'h00, 1'b0);
		drain();
		write_start_key(5'd23);
		send_request(8'h69, 1'b1);
		send_request(8'hff, 1'b1);
		send_request(8'h12, 1'b0);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       phase_key = 5'd0;
				1:       phase_key = 5'd31;
				2:       phase_key = 5'd23;
				3:       phase_key = 5'd24;
				default: phase_key = KEY_W'($urandom_range(31));
			endcase
			write_start_key(phase_key);
			burst = (ph == 2);
			if (ph == 4)
				hold_req++;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(8'($urandom_range(255)), $urandom_range(7) == 0);
			drain();
			burst = 1'b0;
		end

		repeat (ROUNDS + 4) @(posedge clk);
		$display("%0d cipher bytes sent, %0d results checked, %0d restarts, %0d start_key writes",
		         sent, checked, restarts, key_writes);
		$display("includes a stall-free burst and a %0d-cycle output hold-off", HOLD_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("nibble_permutation_cipher_decrypt_core_test OK");
		end else begin
			$display("nibble_permutation_cipher_decrypt_core_test NOT OK");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/npcd_pkg.sv
hw/rtl/npcd_cell.sv
hw/rtl/nibble_permutation_cipher_decrypt_core.sv
tb/npcd_checker.sv
tb/nibble_permutation_cipher_decrypt_core_test.sv
